// ===== rtl/core/anbs_pkg.sv =====
// ----------------------------------------------------------------------------
// anbs_pkg
// Shared types, codes and the start code test for the Annex B NAL splitter.
// ----------------------------------------------------------------------------
package anbs_pkg;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic [2:0] SC_NONE  = 3'd0;
    localparam logic [2:0] SC_SHORT = 3'd3;
    localparam logic [2:0] SC_LONG  = 3'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       unit_first;
        logic       unit_last;
        logic [2:0] start_code_len;
        logic       bad_stream;
        logic       stream_done;
    } t_result;

    // Start code length over the first avail bytes of b0..b3.
    function automatic logic [2:0] code_len(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] avail
    );
        logic [2:0] len;
        len = SC_NONE;
        if (avail >= 3'd3) begin
            if (avail >= 3'd4 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00 && b3 == 8'h01) begin
                len = SC_LONG;
            end else if (b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h01) begin
                len = SC_SHORT;
            end
        end
        return len;
    endfunction

endpackage

// ===== rtl/core/anbs_if.sv =====
// ----------------------------------------------------------------------------
// anbs_if
// Valid/ready channels for stream requests and unit results.
// ----------------------------------------------------------------------------
interface anbs_in_if;
    logic                 valid;
    logic                 ready;
    anbs_pkg::t_item      payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface anbs_out_if;
    logic                 valid;
    logic                 ready;
    anbs_pkg::t_result    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/anbs_window.sv =====
// ----------------------------------------------------------------------------
// anbs_window
// Look-ahead window, unit tracking and end-of-stream drain sequencing.
// ----------------------------------------------------------------------------
module anbs_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  anbs_pkg::t_item     i_item,
    output logic                o_item_ready,
    output logic                o_res_valid,
    output anbs_pkg::t_result   o_res,
    input  logic                i_res_ready
);

    logic [7:0] r_win [4];
    logic [7:0] n_win [4];
    logic [2:0] r_fill, n_fill;
    logic [1:0] r_pos, n_pos;
    logic       r_open, n_open;
    logic       r_disc, n_disc;
    logic       r_flush, n_flush;

    logic       accept;
    logic [2:0] avail;
    logic       head_first;
    logic       head_last;
    logic [2:0] head_len;
    logic [1:0] pos_next;
    logic [7:0] in_byte;

    assign in_byte      = i_item.data_byte;
    assign o_item_ready = !r_flush && i_res_ready;
    assign accept       = i_item_valid && o_item_ready;
    assign avail        = r_flush ? r_fill : 3'd5;

    assign head_first = (r_pos == 2'd0);
    assign head_len   = head_first ?
        anbs_pkg::code_len(r_win[0], r_win[1], r_win[2], r_win[3], avail) : anbs_pkg::SC_NONE;
    assign head_last  = (avail <= 3'd1) || ((r_pos != 2'd0) &&
        (anbs_pkg::code_len(r_win[1], r_win[2], r_win[3], in_byte, avail - 3'd1)
         != anbs_pkg::SC_NONE));
    assign pos_next   = head_last ? 2'd0 : ((r_pos == 2'd2) ? 2'd2 : r_pos + 2'd1);

    always_comb begin
        n_win       = r_win;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_open      = r_open;
        n_disc      = r_disc;
        n_flush     = r_flush;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_flush) begin
            if (i_res_ready) begin
                o_res_valid          = 1'b1;
                o_res.out_byte       = r_win[0];
                o_res.byte_valid     = 1'b1;
                o_res.unit_first     = head_first;
                o_res.unit_last      = head_last;
                o_res.start_code_len = head_len;
                o_res.stream_done    = (r_fill == 3'd1);
                n_win[0] = r_win[1];
                n_win[1] = r_win[2];
                n_win[2] = r_win[3];
                n_fill   = r_fill - 3'd1;
                n_pos    = pos_next;
                if (r_fill <= 3'd1) begin
                    n_fill  = 3'd0;
                    n_pos   = 2'd0;
                    n_open  = 1'b0;
                    n_disc  = 1'b0;
                    n_flush = 1'b0;
                end
            end
        end else if (accept) begin
            if (i_item.kind == anbs_pkg::KIND_DATA) begin
                if (r_disc) begin
                    n_disc = 1'b1;
                end else if (r_open) begin
                    o_res_valid          = 1'b1;
                    o_res.out_byte       = r_win[0];
                    o_res.byte_valid     = 1'b1;
                    o_res.unit_first     = head_first;
                    o_res.unit_last      = head_last;
                    o_res.start_code_len = head_len;
                    n_win[0] = r_win[1];
                    n_win[1] = r_win[2];
                    n_win[2] = r_win[3];
                    n_win[3] = in_byte;
                    n_pos    = pos_next;
                end else begin
                    n_win[r_fill[1:0]] = in_byte;
                    n_fill = r_fill + 3'd1;
                    if (r_fill == 3'd3) begin
                        if (anbs_pkg::code_len(r_win[0], r_win[1], r_win[2], in_byte, 3'd4)
                            != anbs_pkg::SC_NONE) begin
                            n_open = 1'b1;
                            n_pos  = 2'd0;
                        end else begin
                            o_res_valid      = 1'b1;
                            o_res.bad_stream = 1'b1;
                            n_disc           = 1'b1;
                            n_fill           = 3'd0;
                        end
                    end
                end
            end else begin
                if (r_disc) begin
                    o_res_valid       = 1'b1;
                    o_res.stream_done = 1'b1;
                    n_fill = 3'd0;
                    n_pos  = 2'd0;
                    n_open = 1'b0;
                    n_disc = 1'b0;
                end else if (r_open || (r_fill == 3'd3 &&
                    anbs_pkg::code_len(r_win[0], r_win[1], r_win[2], r_win[3], 3'd3)
                    == anbs_pkg::SC_SHORT)) begin
                    n_open  = 1'b1;
                    n_pos   = r_open ? r_pos : 2'd0;
                    n_flush = 1'b1;
                end else begin
                    o_res_valid       = 1'b1;
                    o_res.bad_stream  = (r_fill != 3'd0);
                    o_res.stream_done = 1'b1;
                    n_fill = 3'd0;
                    n_pos  = 2'd0;
                    n_open = 1'b0;
                    n_disc = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= 3'd0;
            r_pos   <= 2'd0;
            r_open  <= 1'b0;
            r_disc  <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_open  <= n_open;
            r_disc  <= n_disc;
            r_flush <= n_flush;
        end
    end

endmodule

// ===== rtl/core/anbs_out_stage.sv =====
// ----------------------------------------------------------------------------
// anbs_out_stage
// Result register with a skid entry so the window waits on the sink only once the skid entry is full.
// ----------------------------------------------------------------------------
module anbs_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  anbs_pkg::t_result   i_res,
    output logic                o_res_ready,
    anbs_out_if.source          o_out
);

    logic              r_out_valid;
    anbs_pkg::t_result r_out;
    logic              r_skid_valid;
    anbs_pkg::t_result r_skid;

    assign o_res_ready   = !r_skid_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end
        if (r_out_valid && !o_out.ready && i_res_valid && !r_skid_valid) begin
            r_skid <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/annexb_nal_unit_splitter.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an H.264 Annex B byte stream into start-code-led NAL units.
// ----------------------------------------------------------------------------
//   port     dir  carries
//   i_in     in   request: kind, data_byte (stream byte or end of stream)
//   o_out    out  result: out_byte, byte_valid, unit_first, unit_last,
//                 start_code_len, bad_stream, stream_done
//
// A data byte is taken every cycle while i_in.ready is high; its result, if
// any, enters the result register, or the skid entry if the sink stalls.
// End of stream with an open unit starts the drain sequencer, which emits
// the pending bytes (up to four). Output has a result register and a skid
// entry; i_in.ready is low during a drain and while the skid entry is full.
// Synchronous active-low reset clears control state; the window is not reset.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    anbs_in_if.sink     i_in,
    anbs_out_if.source  o_out
);

    logic              res_valid;
    logic              res_ready;
    anbs_pkg::t_result res;

    anbs_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in.valid),
        .i_item       (i_in.payload),
        .o_item_ready (i_in.ready),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    anbs_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/core/anbs_checker.sv =====
// ----------------------------------------------------------------------------
// anbs_checker
// Port-level checks on the splitter's result channel.
// ----------------------------------------------------------------------------
module anbs_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  anbs_pkg::t_result i_out_payload
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_first_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.unit_first |->
        i_out_payload.byte_valid &&
        (i_out_payload.start_code_len == anbs_pkg::SC_SHORT ||
         i_out_payload.start_code_len == anbs_pkg::SC_LONG))
        else $error("unit start without a start code length");

    a_bad_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.bad_stream |-> !i_out_payload.byte_valid)
        else $error("bad stream result carries a byte");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.stream_done && i_out_payload.byte_valid |->
        i_out_payload.unit_last)
        else $error("stream ends inside a unit");

endmodule

bind annexb_nal_unit_splitter anbs_checker u_anbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for annexb_nal_unit_splitter.
// Sends Annex B byte streams made of start codes, payload bytes rich in 00
// and 01, garbage and early ends. Each request updates a bit-true splitter
// model, which queues the unit bytes and flags due on the result channel.
// Every result is compared field by field, with both sides stalling at random in all phases but the last.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD     = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    anbs_in_if  in_if ();
    anbs_out_if out_if ();

    annexb_nal_unit_splitter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    logic [7:0]        pend_bytes [5];
    int unsigned       pend_count;
    int unsigned       unit_pos;
    logic              unit_open;
    logic              rejecting;
    anbs_pkg::t_result unit_results_due [$];

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int fail_count       = 0;
    int results_checked  = 0;
    int live_items       = 0;
    int streams_sent     = 0;
    int streams_rejected = 0;
    int units_seen       = 0;
    int idle_cycles      = 0;

    function automatic logic [2:0] start_code_at(int unsigned at, int unsigned avail);
        logic [2:0] len;
        len = anbs_pkg::SC_NONE;
        if (avail >= 4 && pend_bytes[at] == 8'h00 && pend_bytes[at+1] == 8'h00 &&
            pend_bytes[at+2] == 8'h00 && pend_bytes[at+3] == 8'h01) begin
            len = anbs_pkg::SC_LONG;
        end else if (avail >= 3 && pend_bytes[at] == 8'h00 && pend_bytes[at+1] == 8'h00 &&
                     pend_bytes[at+2] == 8'h01) begin
            len = anbs_pkg::SC_SHORT;
        end
        return len;
    endfunction

    function automatic void clear_split_state();
        pend_count = 0;
        unit_pos   = 0;
        unit_open  = 1'b0;
        rejecting  = 1'b0;
    endfunction

    function automatic void push_flags(logic bad, logic done);
        anbs_pkg::t_result r;
        r             = '0;
        r.bad_stream  = bad;
        r.stream_done = done;
        if (bad) streams_rejected++;
        unit_results_due.push_back(r);
    endfunction

    function automatic void emit_oldest(logic done);
        anbs_pkg::t_result r;
        logic              last;
        r = '0;
        if (pend_count <= 1) begin
            last = 1'b1;
        end else begin
            last = (unit_pos >= 1) &&
                   (start_code_at(1, pend_count - 1) != anbs_pkg::SC_NONE);
        end
        r.out_byte       = pend_bytes[0];
        r.byte_valid     = 1'b1;
        r.unit_first     = (unit_pos == 0);
        r.unit_last      = last;
        r.start_code_len = r.unit_first ? start_code_at(0, pend_count) : anbs_pkg::SC_NONE;
        r.stream_done    = done;
        unit_results_due.push_back(r);
        for (int i = 0; i < 4; i++) pend_bytes[i] = pend_bytes[i+1];
        if (pend_count > 0) pend_count--;
        unit_pos = last ? 0 : (unit_pos < 2 ? unit_pos + 1 : 2);
    endfunction

    function automatic void split_request(anbs_pkg::t_item req);
        int n;
        n = 0;
        if (req.kind == anbs_pkg::KIND_DATA) begin
            if (rejecting) return;
            if (pend_count < 5) begin
                pend_bytes[pend_count] = req.data_byte;
                pend_count++;
            end
            if (unit_open) begin
                if (pend_count == 5) emit_oldest(1'b0);
            end else if (pend_count >= 4) begin
                if (start_code_at(0, 4) != anbs_pkg::SC_NONE) begin
                    unit_open = 1'b1;
                    unit_pos  = 0;
                end else begin
                    push_flags(1'b1, 1'b0);
                    rejecting  = 1'b1;
                    pend_count = 0;
                end
            end
        end else begin
            streams_sent++;
            if (rejecting) begin
                push_flags(1'b0, 1'b1);
            end else if (!unit_open &&
                         !(pend_count >= 3 &&
                           start_code_at(0, pend_count) != anbs_pkg::SC_NONE)) begin
                push_flags(pend_count != 0, 1'b1);
            end else begin
                while (pend_count > 0 && n < 4) begin
                    emit_oldest(pend_count == 1);
                    n++;
                end
                if (n == 0) push_flags(1'b0, 1'b1);
            end
            clear_split_state();
        end
    endfunction

    function automatic logic [7:0] stream_byte();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) return 8'h00;
        if (pick < 60) return 8'h01;
        return 8'($urandom_range(255));
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("MISMATCH at result %0d: %s", results_checked, what);
        end
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    task automatic send_request(logic kind, logic [7:0] data);
        anbs_pkg::t_item req;
        req.kind      = kind;
        req.data_byte = data;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        if (!(kind == anbs_pkg::KIND_DATA && rejecting)) live_items++;
        split_request(req);
        in_if.valid   <= 1'b1;
        in_if.payload <= req;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_data(logic [63:0] bytes, int count);
        for (int i = count - 1; i >= 0; i--) send_request(anbs_pkg::KIND_DATA, bytes[i*8 +: 8]);
    endtask

    task automatic end_stream();
        send_request(anbs_pkg::KIND_EOS, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (unit_results_due.size() != 0);
    endtask

    task automatic test_empty_stream();
        end_stream();
    endtask

    task automatic test_bare_short_code();
        send_data(64'h000001, 3);
        end_stream();
    endtask

    task automatic test_short_garbage();
        send_data(64'h000000, 3);
        end_stream();
    endtask

    task automatic test_long_code_and_trailing_unit();
        send_data(64'h00000001ff000001, 8);
        end_stream();
    endtask

    task automatic test_rejected_stream();
        send_data(64'h7f00000155, 5);
        end_stream();
    endtask

    task automatic send_random_stream();
        int unsigned shape;
        shape = $urandom_range(99);
        if (shape < 70) begin
            if ($urandom_range(1) == 1) send_request(anbs_pkg::KIND_DATA, 8'h00);
            send_data(64'h000001, 3);
            repeat ($urandom_range(12)) begin
                if ($urandom_range(9) == 0) send_data(64'h000001, 3);
                else send_request(anbs_pkg::KIND_DATA, stream_byte());
            end
        end else if (shape < 85) begin
            repeat ($urandom_range(1, 8)) send_request(anbs_pkg::KIND_DATA, stream_byte());
        end else begin
            repeat ($urandom_range(3)) send_request(anbs_pkg::KIND_DATA, stream_byte());
        end
        end_stream();
        if ($urandom_range(7) == 0) wait_drained();
    endtask

    task automatic test_random_streams(int sender_idle, int receiver_idle);
        int target;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        target        = live_items + ITEMS_PER_PHASE;
        while (live_items < target) send_random_stream();
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        anbs_pkg::t_result got;
        anbs_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (unit_results_due.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = unit_results_due.pop_front();
                compare_field("out_byte", got.out_byte, want.out_byte);
                compare_field("byte_valid", got.byte_valid, want.byte_valid);
                compare_field("unit_first", got.unit_first, want.unit_first);
                compare_field("unit_last", got.unit_last, want.unit_last);
                compare_field("start_code_len", got.start_code_len, want.start_code_len);
                compare_field("bad_stream", got.bad_stream, want.bad_stream);
                compare_field("stream_done", got.stream_done, want.stream_done);
            end
            if (got.byte_valid && got.unit_first) units_seen++;
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        clear_split_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 63;
        test_empty_stream();
        test_bare_short_code();
        test_short_garbage();
        test_long_code_and_trailing_unit();
        test_rejected_stream();
        wait_drained();

        test_random_streams(9, 63);
        test_random_streams(63, 9);
        test_random_streams(0, 0);

        in_if.valid <= 1'b0;
        while (unit_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d streams (%0d rejected), %0d units, %0d results checked",
                 streams_sent, streams_rejected, units_seen, results_checked);
        $display("stall mixes: sender-light/receiver-heavy, reversed, and none");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
